// File: design/maze_dfs_explorer_top_macros.svh
// Assertion macros for the maze explorer top level.
// Expects clk and arst_n in the scope of each use.
`ifndef MAZE_DFS_EXPLORER_TOP_MACROS_SVH
`define MAZE_DFS_EXPLORER_TOP_MACROS_SVH

`define MDE_ASSERT_HOLDS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define MDE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/mde_pkg.sv
// Shared types, codes and the sequencer microprogram for the maze explorer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mde_pkg;

	localparam int MAX_COLS_DEF    = 16;
	localparam int MAX_ROWS_DEF    = 16;
	localparam int STACK_DEPTH_DEF = 512;

	typedef enum logic [2:0] {
		ACT_MARK  = 3'd0,
		ACT_LEFT  = 3'd1,
		ACT_RIGHT = 3'd2,
		ACT_FWD   = 3'd3,
		ACT_DONE  = 3'd4
	} act_t;

	typedef enum logic [1:0] {
		REG_WIDTH   = 2'd0,
		REG_HEIGHT  = 2'd1,
		REG_START_X = 2'd2,
		REG_START_Y = 2'd3
	} reg_idx_t;

	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_E = 2'd1;
	localparam logic [1:0] DIR_S = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_CLEAR,
		OP_START,
		OP_POP,
		OP_LOAD,
		OP_EMARK,
		OP_PROBE,
		OP_NEXTDIR,
		OP_BACKRD,
		OP_BACKDIR,
		OP_PUSHCUR,
		OP_PUSHNB,
		OP_TURN,
		OP_EFWD,
		OP_EDONE
	} op_t;

	typedef enum logic [2:0] {
		C_NONE,
		C_ALWAYS,
		C_NOBEGIN,
		C_IDLE,
		C_HIT,
		C_MORE,
		C_EMPTY
	} cond_t;

	typedef logic [4:0] pc_t;

	localparam pc_t PC_WAIT    = 5'd0;
	localparam pc_t PC_CLR     = 5'd1;
	localparam pc_t PC_START   = 5'd2;
	localparam pc_t PC_CHK     = 5'd3;
	localparam pc_t PC_POP     = 5'd4;
	localparam pc_t PC_LOAD    = 5'd5;
	localparam pc_t PC_MARK    = 5'd6;
	localparam pc_t PC_PROBE   = 5'd7;
	localparam pc_t PC_TEST    = 5'd8;
	localparam pc_t PC_NEXT    = 5'd9;
	localparam pc_t PC_BACK    = 5'd10;
	localparam pc_t PC_BACKDIR = 5'd11;
	localparam pc_t PC_PUSHCUR = 5'd12;
	localparam pc_t PC_PUSHNB  = 5'd13;
	localparam pc_t PC_TURN    = 5'd14;
	localparam pc_t PC_FWD     = 5'd15;
	localparam pc_t PC_DONE    = 5'd16;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ctrl_t;

	function automatic ctrl_t ucode(input pc_t pc);
		ctrl_t w;
		unique case (pc)
			PC_WAIT:    w = '{op: OP_ACCEPT,  cond: C_NOBEGIN, target: PC_CHK};
			PC_CLR:     w = '{op: OP_CLEAR,   cond: C_NONE,    target: PC_WAIT};
			PC_START:   w = '{op: OP_START,   cond: C_NONE,    target: PC_WAIT};
			PC_CHK:     w = '{op: OP_NOP,     cond: C_IDLE,    target: PC_DONE};
			PC_POP:     w = '{op: OP_POP,     cond: C_NONE,    target: PC_WAIT};
			PC_LOAD:    w = '{op: OP_LOAD,    cond: C_NONE,    target: PC_WAIT};
			PC_MARK:    w = '{op: OP_EMARK,   cond: C_NONE,    target: PC_WAIT};
			PC_PROBE:   w = '{op: OP_PROBE,   cond: C_NONE,    target: PC_WAIT};
			PC_TEST:    w = '{op: OP_NOP,     cond: C_HIT,     target: PC_PUSHCUR};
			PC_NEXT:    w = '{op: OP_NEXTDIR, cond: C_MORE,    target: PC_PROBE};
			PC_BACK:    w = '{op: OP_BACKRD,  cond: C_EMPTY,   target: PC_DONE};
			PC_BACKDIR: w = '{op: OP_BACKDIR, cond: C_ALWAYS,  target: PC_TURN};
			PC_PUSHCUR: w = '{op: OP_PUSHCUR, cond: C_NONE,    target: PC_WAIT};
			PC_PUSHNB:  w = '{op: OP_PUSHNB,  cond: C_NONE,    target: PC_WAIT};
			PC_TURN:    w = '{op: OP_TURN,    cond: C_NONE,    target: PC_WAIT};
			PC_FWD:     w = '{op: OP_EFWD,    cond: C_ALWAYS,  target: PC_WAIT};
			PC_DONE:    w = '{op: OP_EDONE,   cond: C_ALWAYS,  target: PC_WAIT};
			default:    w = '{op: OP_NOP,     cond: C_ALWAYS,  target: PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// File: design/mde_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: design/maze_dfs_explorer_top.sv
// A step stalls while the result side is busy; it emits up to 4 words.
// A begin word adds one sweep over the visited map, clearing 2**(clog2(MAX_COLS)+clog2(MAX_ROWS))
// entries (256 at 16 x 16), and then seeds the stack.
// Throughput: one input word per step; the microprogram runs one step at a time.
// Reset: sequencer idle, stack empty, heading north, finished set; the visited map
// is not cleared at reset, the begin sweep clears it before any read.
// Maze explorer top level: microcoded sequencer, datapath and the two RAMs.
// Depends on mde_pkg, mde_ram and maze_dfs_explorer_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "maze_dfs_explorer_top_macros.svh"

module maze_dfs_explorer_top #(
	parameter int MAX_COLS    = mde_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS    = mde_pkg::MAX_ROWS_DEF,
	parameter int STACK_DEPTH = mde_pkg::STACK_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // wall_ahead, wall_on_right, wall_on_left, pad
	input  wire logic [0:0] s_axis_tuser,   // begin_req
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic      [7:0] m_axis_tdata,   // cell_col[3:0], cell_row[7:4]
	output logic      [2:0] m_axis_tuser,   // action
	output logic            m_axis_tlast,   // last
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [4:0] cfg_data
);

	localparam int CW   = $clog2(MAX_COLS);
	localparam int RW   = $clog2(MAX_ROWS);
	localparam int CWP  = CW + 1;
	localparam int RWP  = RW + 1;
	localparam int MAPW = CW + RW;
	localparam int SEW  = CW + RW + 2;
	localparam int SAW  = $clog2(STACK_DEPTH);
	localparam int SPW  = $clog2(STACK_DEPTH + 1);

	logic [4:0] maze_width_q;
	logic [4:0] maze_height_q;
	logic [3:0] start_x_q;
	logic [3:0] start_y_q;

	mde_pkg::pc_t   pc_q;
	mde_pkg::pc_t   pc_d;
	mde_pkg::ctrl_t ctrl;

	logic [SPW-1:0]  sp_q;
	logic [SPW-1:0]  sp_dec;
	logic [1:0]      heading_q;
	logic            finished_q;
	logic [MAPW-1:0] clr_q;

	logic [CW-1:0] x_q;
	logic [RW-1:0] y_q;
	logic [1:0]    d_q;
	logic [1:0]    tgt_q;
	logic          ok_q;
	logic          wa_q;
	logic          wr_q;
	logic          wl_q;

	logic            out_valid_q;
	logic [2:0]      out_act_q;
	logic [3:0]      out_col_q;
	logic [3:0]      out_row_q;
	logic            out_last_q;

	logic [CWP-1:0] w_eff;
	logic [RWP-1:0] h_eff;
	logic [CW-1:0]  sx_c;
	logic [RW-1:0]  sy_c;
	logic [CW-1:0]  nx_c;
	logic [RW-1:0]  ny_c;
	logic           inb_c;
	logic           wall_c;
	logic           hit_c;
	logic           push_ok;
	logic           turn_left;
	logic           out_free;
	logic           emit_req;
	logic           out_load;
	mde_pkg::act_t  out_act_c;
	logic [3:0]     out_col_c;
	logic [3:0]     out_row_c;
	logic           out_last_c;
	logic           stall;
	logic           cond_true;

	logic            stk_we;
	logic [SAW-1:0]  stk_waddr;
	logic [SEW-1:0]  stk_wdata;
	logic [SAW-1:0]  stk_raddr;
	logic [SEW-1:0]  stk_rdata;
	logic            vis_we;
	logic [MAPW-1:0] vis_waddr;
	logic            vis_wdata;
	logic [MAPW-1:0] vis_raddr;
	logic            vis_rdata;

	assign ctrl          = mde_pkg::ucode(pc_q);
	assign s_axis_tready = (pc_q == mde_pkg::PC_WAIT);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_row_q, out_col_q};
	assign m_axis_tuser  = out_act_q;
	assign m_axis_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maze_width_q  <= 5'd16;
			maze_height_q <= 5'd16;
			start_x_q     <= 4'd0;
			start_y_q     <= 4'd0;
		end else if (cfg_valid) begin
			unique case (mde_pkg::reg_idx_t'(cfg_index))
				mde_pkg::REG_WIDTH:   maze_width_q  <= cfg_data;
				mde_pkg::REG_HEIGHT:  maze_height_q <= cfg_data;
				mde_pkg::REG_START_X: start_x_q     <= cfg_data[3:0];
				mde_pkg::REG_START_Y: start_y_q     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (maze_width_q == '0) begin
			w_eff = CWP'(1);
		end else if (32'(maze_width_q) > MAX_COLS) begin
			w_eff = CWP'(MAX_COLS);
		end else begin
			w_eff = CWP'(maze_width_q);
		end
		if (maze_height_q == '0) begin
			h_eff = RWP'(1);
		end else if (32'(maze_height_q) > MAX_ROWS) begin
			h_eff = RWP'(MAX_ROWS);
		end else begin
			h_eff = RWP'(maze_height_q);
		end
		if (32'(start_x_q) > 32'(w_eff) - 1) begin
			sx_c = CW'(w_eff - 1'b1);
		end else begin
			sx_c = CW'(start_x_q);
		end
		if (32'(start_y_q) > 32'(h_eff) - 1) begin
			sy_c = RW'(h_eff - 1'b1);
		end else begin
			sy_c = RW'(start_y_q);
		end
	end

	always_comb begin
		nx_c  = x_q;
		ny_c  = y_q;
		inb_c = 1'b0;
		case (d_q)
			mde_pkg::DIR_N: begin
				ny_c  = y_q + 1'b1;
				inb_c = ({1'b0, y_q} + 1'b1) < h_eff;
			end
			mde_pkg::DIR_E: begin
				nx_c  = x_q + 1'b1;
				inb_c = ({1'b0, x_q} + 1'b1) < w_eff;
			end
			mde_pkg::DIR_S: begin
				ny_c  = y_q - 1'b1;
				inb_c = (y_q != '0);
			end
			default: begin
				nx_c  = x_q - 1'b1;
				inb_c = (x_q != '0);
			end
		endcase
		if (d_q == heading_q) begin
			wall_c = wa_q;
		end else if (d_q == heading_q + 2'd1) begin
			wall_c = wr_q;
		end else if (d_q == heading_q + 2'd3) begin
			wall_c = wl_q;
		end else begin
			wall_c = 1'b1;
		end
		hit_c     = ok_q && !vis_rdata && !wall_c;
		push_ok   = sp_q < SPW'(STACK_DEPTH);
		sp_dec    = sp_q - 1'b1;
		turn_left = (heading_q - tgt_q) <= (tgt_q - heading_q);
	end

	always_comb begin
		out_free   = !out_valid_q || m_axis_tready;
		emit_req   = 1'b0;
		out_act_c  = mde_pkg::ACT_MARK;
		out_col_c  = 4'd0;
		out_row_c  = 4'd0;
		out_last_c = 1'b0;
		stall      = 1'b0;
		unique case (ctrl.op)
			mde_pkg::OP_ACCEPT: stall = !s_axis_tvalid;
			mde_pkg::OP_CLEAR:  stall = (clr_q != '1);
			mde_pkg::OP_EMARK: begin
				emit_req  = 1'b1;
				out_col_c = 4'(x_q);
				out_row_c = 4'(y_q);
				stall     = !out_free;
			end
			mde_pkg::OP_TURN: begin
				emit_req  = (heading_q != tgt_q);
				out_act_c = turn_left ? mde_pkg::ACT_LEFT : mde_pkg::ACT_RIGHT;
				stall     = (heading_q != tgt_q);
			end
			mde_pkg::OP_EFWD: begin
				emit_req   = 1'b1;
				out_act_c  = mde_pkg::ACT_FWD;
				out_last_c = 1'b1;
				stall      = !out_free;
			end
			mde_pkg::OP_EDONE: begin
				emit_req   = 1'b1;
				out_act_c  = mde_pkg::ACT_DONE;
				out_last_c = 1'b1;
				stall      = !out_free;
			end
			default: ;
		endcase
		out_load = emit_req && out_free;

		unique case (ctrl.cond)
			mde_pkg::C_NONE:    cond_true = 1'b0;
			mde_pkg::C_ALWAYS:  cond_true = 1'b1;
			mde_pkg::C_NOBEGIN: cond_true = !s_axis_tuser[0];
			mde_pkg::C_IDLE:    cond_true = finished_q || (sp_q == '0);
			mde_pkg::C_HIT:     cond_true = hit_c;
			mde_pkg::C_MORE:    cond_true = (d_q != mde_pkg::DIR_W);
			mde_pkg::C_EMPTY:   cond_true = (sp_q == '0);
			default:            cond_true = 1'b1;
		endcase

		if (stall) begin
			pc_d = pc_q;
		end else if (cond_true) begin
			pc_d = ctrl.target;
		end else begin
			pc_d = pc_q + 1'b1;
		end
	end

	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = sp_q[SAW-1:0];
		stk_wdata = {d_q, y_q, x_q};
		stk_raddr = sp_dec[SAW-1:0];
		vis_we    = 1'b0;
		vis_waddr = {ny_c, nx_c};
		vis_wdata = 1'b1;
		vis_raddr = {ny_c, nx_c};
		case (ctrl.op)
			mde_pkg::OP_CLEAR: begin
				vis_we    = 1'b1;
				vis_waddr = clr_q;
				vis_wdata = 1'b0;
			end
			mde_pkg::OP_START: begin
				stk_we    = 1'b1;
				stk_waddr = '0;
				stk_wdata = {mde_pkg::DIR_N, sy_c, sx_c};
				vis_we    = 1'b1;
				vis_waddr = {sy_c, sx_c};
			end
			mde_pkg::OP_PUSHCUR: stk_we = push_ok;
			mde_pkg::OP_PUSHNB: begin
				stk_we    = push_ok;
				stk_wdata = {d_q, ny_c, nx_c};
				vis_we    = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= mde_pkg::PC_WAIT;
			sp_q        <= '0;
			heading_q   <= mde_pkg::DIR_N;
			finished_q  <= 1'b1;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (ctrl.op)
				mde_pkg::OP_CLEAR: clr_q <= clr_q + 1'b1;
				mde_pkg::OP_START: begin
					sp_q       <= SPW'(1);
					heading_q  <= mde_pkg::DIR_N;
					finished_q <= 1'b0;
				end
				mde_pkg::OP_POP: sp_q <= sp_dec;
				mde_pkg::OP_PUSHCUR, mde_pkg::OP_PUSHNB: begin
					if (push_ok) begin
						sp_q <= sp_q + 1'b1;
					end
				end
				mde_pkg::OP_TURN: begin
					if (out_load) begin
						heading_q <= turn_left ? heading_q - 2'd1 : heading_q + 2'd1;
					end
				end
				mde_pkg::OP_EDONE: begin
					if (out_load) begin
						finished_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_act_q  <= out_act_c;
			out_col_q  <= out_col_c;
			out_row_q  <= out_row_c;
			out_last_q <= out_last_c;
		end
		case (ctrl.op)
			mde_pkg::OP_ACCEPT: begin
				wa_q <= s_axis_tdata[0];
				wr_q <= s_axis_tdata[1];
				wl_q <= s_axis_tdata[2];
			end
			mde_pkg::OP_LOAD: begin
				x_q <= stk_rdata[CW-1:0];
				y_q <= stk_rdata[MAPW-1:CW];
				d_q <= mde_pkg::DIR_N;
			end
			mde_pkg::OP_PROBE:   ok_q  <= inb_c;
			mde_pkg::OP_NEXTDIR: d_q   <= d_q + 2'd1;
			mde_pkg::OP_BACKDIR: tgt_q <= stk_rdata[SEW-1:MAPW] + 2'd2;
			mde_pkg::OP_PUSHCUR: tgt_q <= d_q;
			default: ;
		endcase
	end

	mde_ram #(
		.WIDTH(SEW),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	mde_ram #(
		.WIDTH(1),
		.DEPTH(2 ** MAPW)
	) u_visited (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.raddr (vis_raddr),
		.rdata (vis_rdata)
	);

	`MDE_ASSERT_HOLDS(a_sp_bound, sp_q <= SPW'(STACK_DEPTH), "stack count beyond depth")
	`MDE_ASSERT_NEXT(a_done_sets_finished, out_load && (ctrl.op == mde_pkg::OP_EDONE), finished_q, "finished not set after done word")
	`MDE_ASSERT_NEXT(a_last_to_wait, out_load && out_last_c, pc_q == mde_pkg::PC_WAIT, "sequencer not idle after last word")
	`MDE_ASSERT_NEXT(a_heading_hold, (ctrl.op != mde_pkg::OP_TURN) && (ctrl.op != mde_pkg::OP_START), $stable(heading_q), "heading moved outside turn or start")

endmodule

`default_nettype wire

// File: sim/maze_dfs_explorer_checker.sv
`timescale 1ns / 1ps
// Checker for the maze explorer: follows register writes and input words, predicts the
// result words of every exploration step and compares them with the output stream.
// Depends on mde_pkg.
module maze_dfs_explorer_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	input  wire logic       s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // wall_ahead, wall_on_right, wall_on_left, pad
	input  wire logic [0:0] s_axis_tuser,   // begin_req
	input  wire logic       m_axis_tvalid,
	input  wire logic       m_axis_tready,
	input  wire logic [7:0] m_axis_tdata,   // cell_col[3:0], cell_row[7:4]
	input  wire logic [2:0] m_axis_tuser,   // action
	input  wire logic       m_axis_tlast,   // last
	input  wire logic       cfg_valid,
	input  wire logic       cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [4:0] cfg_data,
	output int              mismatches,
	output int              backlog,
	output int              words_out
);

	localparam int COLS  = mde_pkg::MAX_COLS_DEF;
	localparam int ROWS  = mde_pkg::MAX_ROWS_DEF;
	localparam int DEPTH = mde_pkg::STACK_DEPTH_DEF;

	typedef struct {
		mde_pkg::act_t action;
		logic [3:0]    col;
		logic [3:0]    row;
		logic          last;
	} move_t;

	move_t moves_due[$];
	move_t step_moves[$];

	logic [4:0] maze_w, maze_h;
	logic [3:0] start_col, start_row;
	bit         visited [COLS*ROWS];
	logic [3:0] trail_col [DEPTH];
	logic [3:0] trail_row [DEPTH];
	logic [1:0] trail_dir [DEPTH];
	int         trail_len;
	logic [1:0] heading;
	bit         done;

	function automatic int clamp_size(input logic [4:0] v, input int hi);
		if (v == 0)
			return 1;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	task automatic trail_push(input int x, input int y, input logic [1:0] d);
		if (trail_len >= DEPTH)
			return;
		trail_col[trail_len] = 4'(x);
		trail_row[trail_len] = 4'(y);
		trail_dir[trail_len] = d;
		trail_len++;
	endtask

	task automatic emit(input mde_pkg::act_t a, input logic [3:0] c, input logic [3:0] r);
		move_t m;
		m.action = a;
		m.col    = c;
		m.row    = r;
		m.last   = 1'b0;
		step_moves.push_back(m);
	endtask

	task automatic face_and_go(input logic [1:0] dir);
		logic [1:0] lt, rt;
		lt = heading - dir;
		rt = dir - heading;
		if (lt <= rt) begin
			repeat (lt) emit(mde_pkg::ACT_LEFT, 4'd0, 4'd0);
		end else begin
			repeat (rt) emit(mde_pkg::ACT_RIGHT, 4'd0, 4'd0);
		end
		heading = dir;
		emit(mde_pkg::ACT_FWD, 4'd0, 4'd0);
	endtask

	task automatic explore_step(input logic begin_req, input logic [2:0] walls);
		int         w, h, sx, sy, x, y, nx, ny;
		logic [1:0] d, right_dir, left_dir;
		bit         found, ok, blocked;
		w = clamp_size(maze_w, COLS);
		h = clamp_size(maze_h, ROWS);
		step_moves.delete();
		if (begin_req) begin
			sx = int'(start_col);
			sy = int'(start_row);
			if (sx > w - 1)
				sx = w - 1;
			if (sy > h - 1)
				sy = h - 1;
			foreach (visited[i])
				visited[i] = 1'b0;
			heading = mde_pkg::DIR_N;
			trail_len = 0;
			trail_push(sx, sy, mde_pkg::DIR_N);
			visited[sy*COLS+sx] = 1'b1;
			done = 1'b0;
		end
		if (done || trail_len == 0) begin
			done = 1'b1;
			emit(mde_pkg::ACT_DONE, 4'd0, 4'd0);
		end else begin
			trail_len--;
			x = int'(trail_col[trail_len]);
			y = int'(trail_row[trail_len]);
			emit(mde_pkg::ACT_MARK, 4'(x), 4'(y));
			found = 1'b0;
			right_dir = heading + 2'd1;
			left_dir = heading + 2'd3;
			for (int i = 0; i < 4 && !found; i++) begin
				d = 2'(i);
				nx = x;
				ny = y;
				case (d)
					mde_pkg::DIR_N: begin
						ok = (y + 1 < h);
						ny = y + 1;
					end
					mde_pkg::DIR_E: begin
						ok = (x + 1 < w);
						nx = x + 1;
					end
					mde_pkg::DIR_S: begin
						ok = (y > 0);
						ny = y - 1;
					end
					default: begin
						ok = (x > 0);
						nx = x - 1;
					end
				endcase
				if (ok) begin
					if (!visited[ny*COLS+nx]) begin
						if (d == heading)
							blocked = walls[0];
						else if (d == right_dir)
							blocked = walls[1];
						else if (d == left_dir)
							blocked = walls[2];
						else
							blocked = 1'b1;
						if (!blocked) begin
							trail_push(x, y, d);
							face_and_go(d);
							trail_push(nx, ny, d);
							visited[ny*COLS+nx] = 1'b1;
							found = 1'b1;
						end
					end
				end
			end
			if (!found) begin
				if (trail_len > 0) begin
					face_and_go(trail_dir[trail_len-1] + 2'd2);
				end else begin
					done = 1'b1;
					emit(mde_pkg::ACT_DONE, 4'd0, 4'd0);
				end
			end
		end
		step_moves[step_moves.size()-1].last = 1'b1;
		foreach (step_moves[i])
			moves_due.push_back(step_moves[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		move_t want;
		if (!arst_n) begin
			maze_w = 5'd16;
			maze_h = 5'd16;
			start_col = 4'd0;
			start_row = 4'd0;
			foreach (visited[i])
				visited[i] = 1'b0;
			trail_len = 0;
			heading = mde_pkg::DIR_N;
			done = 1'b1;
			moves_due.delete();
			mismatches = 0;
			words_out = 0;
			backlog = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mde_pkg::REG_WIDTH:   maze_w = cfg_data;
					mde_pkg::REG_HEIGHT:  maze_h = cfg_data;
					mde_pkg::REG_START_X: start_col = cfg_data[3:0];
					mde_pkg::REG_START_Y: start_row = cfg_data[3:0];
					default:     ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				explore_step(s_axis_tuser[0], s_axis_tdata[2:0]);
			if (m_axis_tvalid && m_axis_tready) begin
				words_out++;
				if (moves_due.size() == 0) begin
					mismatches++;
					$error("unexpected result word: action %0d, col %0d, row %0d, last %0d",
						m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[7:4], m_axis_tlast);
				end else begin
					want = moves_due.pop_front();
					if (m_axis_tuser !== want.action) begin
						mismatches++;
						$error("action: expected %0d, got %0d", want.action, m_axis_tuser);
					end
					if (m_axis_tdata[3:0] !== want.col) begin
						mismatches++;
						$error("cell_col: expected %0d, got %0d", want.col, m_axis_tdata[3:0]);
					end
					if (m_axis_tdata[7:4] !== want.row) begin
						mismatches++;
						$error("cell_row: expected %0d, got %0d", want.row, m_axis_tdata[7:4]);
					end
					if (m_axis_tlast !== want.last) begin
						mismatches++;
						$error("last: expected %0d, got %0d", want.last, m_axis_tlast);
					end
				end
			end
			backlog = moves_due.size();
		end
	end

endmodule

// File: sim/tb_maze_dfs_explorer_top.sv
`timescale 1ns / 1ps
// Testbench top for the maze explorer: drives sensor words and register writes with
// random idling, and gives the verdict. Depends on mde_pkg, maze_dfs_explorer_top and
// maze_dfs_explorer_checker.
module tb_maze_dfs_explorer_top;

	localparam int LONG_HOLD   = 300;
	localparam int TOTAL_WORDS = 450;
	localparam int CALM_AFTER  = 380;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic [0:0] s_axis_tuser;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic       m_axis_tlast;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [4:0] cfg_data;

	int mismatches, backlog, words_out;
	int words_sent = 0;
	int words_in = 0;
	int settings = 0;
	bit calm = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	maze_dfs_explorer_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	maze_dfs_explorer_checker check_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.backlog(backlog),
		.words_out(words_out)
	);

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			words_in <= words_in + 1;
	end

	function automatic logic [2:0] random_walls();
		return {$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0};
	endfunction

	function automatic logic [4:0] pick_size();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 5'd0;
		if (r == 1)
			return 5'($urandom_range(17, 31));
		if (r <= 3)
			return 5'($urandom_range(7, 16));
		return 5'($urandom_range(1, 6));
	endfunction

	function automatic int eff_size(input logic [4:0] v);
		if (v == 0)
			return 1;
		if (v > 16)
			return 16;
		return int'(v);
	endfunction

	task automatic send_word(input logic begin_req, input logic [2:0] walls);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= begin_req;
		s_axis_tdata <= {5'b0, walls};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		words_sent++;
		if (words_sent >= CALM_AFTER)
			calm = 1'b1;
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// drain every expected word, then give the sequencer time to return to idle
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (backlog != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic cfg_word(input mde_pkg::reg_idx_t idx, input logic [4:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_maze(input logic [4:0] w, input logic [4:0] h,
			input logic [4:0] sx, input logic [4:0] sy);
		cfg_word(mde_pkg::REG_WIDTH, w);
		cfg_word(mde_pkg::REG_HEIGHT, h);
		cfg_word(mde_pkg::REG_START_X, sx);
		cfg_word(mde_pkg::REG_START_Y, sy);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// receiver: random stalls, one long hold once traffic is flowing
	initial begin : receiver
		bit held_off;
		held_off = 1'b0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held_off && words_in >= 40 && s_axis_tvalid) begin
				held_off = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("maze_dfs_explorer_top test failed");
		$finish;
	end

	initial begin : stimulus
		int         steps;
		logic [4:0] w, h;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'd0;
		s_axis_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = mde_pkg::REG_WIDTH;
		cfg_data = 5'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// idle, then a short walk on the reset 16 x 16 maze with a reversal
		send_word(1'b0, 3'b111);
		send_word(1'b1, 3'b000);
		send_word(1'b0, 3'b111);
		send_word(1'b0, 3'b000);
		send_word(1'b0, 3'b010);
		send_word(1'b0, 3'b100);
		send_word(1'b0, 3'b001);
		settle();
		set_maze(5'd1, 5'd1, 5'd0, 5'd0);
		send_word(1'b1, 3'b000);
		send_word(1'b0, 3'b000);
		settle();
		set_maze(5'd0, 5'd0, 5'd15, 5'd15);
		send_word(1'b1, 3'b111);
		settle();
		set_maze(5'd31, 5'd31, 5'd15, 5'd15);
		send_word(1'b1, 3'b000);
		send_word(1'b0, 3'b111);
		send_word(1'b0, 3'b000);
		settle();
		set_maze(5'd2, 5'd16, 5'd9, 5'd3);
		send_word(1'b1, 3'b000);
		send_word(1'b0, 3'b000);
		send_word(1'b0, 3'b000);
		settle();
		set_maze(5'd16, 5'd3, 5'd9, 5'd3);
		send_word(1'b0, 3'b000);
		send_word(1'b0, 3'b101);
		send_word(1'b1, 3'b011);
		settle();

		while (words_sent < TOTAL_WORDS) begin
			w = pick_size();
			h = pick_size();
			set_maze(w, h, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
			steps = 2 * eff_size(w) * eff_size(h) + int'($urandom_range(1, 3));
			if (steps > 60)
				steps = 60;
			send_word(1'b1, random_walls());
			for (int i = 0; i < steps && words_sent < TOTAL_WORDS; i++) begin
				if ($urandom_range(0, 39) == 0) begin
					send_word(1'b1, random_walls());
				end else if ($urandom_range(0, 39) == 0) begin
					settle();
					set_maze(pick_size(), pick_size(), 5'($urandom_range(0, 31)),
						5'($urandom_range(0, 31)));
				end else begin
					send_word(1'b0, random_walls());
				end
			end
			settle();
		end

		$display("Sent %0d sensor words over %0d maze settings, checked %0d result words",
			words_sent, settings, words_out);
		$display("Run covered idle steps, 1x1 and saturated sizes, clamped starts, resizes");
		if (mismatches == 0 && backlog == 0) begin
			$display("maze_dfs_explorer_top test passed");
		end else begin
			$display("maze_dfs_explorer_top test failed");
		end
		$finish;
	end

endmodule

// File: maze_dfs_explorer_top.f
+incdir+design
design/mde_pkg.sv
design/mde_ram.sv
design/maze_dfs_explorer_top.sv
sim/maze_dfs_explorer_checker.sv
sim/tb_maze_dfs_explorer_top.sv
